[sv/sample_capture_framer_assert.svh]
// Assertion macros for the sample capture framer.
// Expects signals clk and rst_n in the including scope.
`ifndef SAMPLE_CAPTURE_FRAMER_ASSERT_SVH
`define SAMPLE_CAPTURE_FRAMER_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define SCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, idle during reset.
`define SCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/scf_pkg.sv]
// Shared types and constants for the sample capture framer.
// No dependencies; used by scf_ctrl, scf_dp and sample_capture_framer.
package scf_pkg;

  localparam int RING_DEPTH_DEF      = 64;
  localparam int BATCH_SIZE_DEF      = 8;
  localparam int MAX_SET_SAMPLES_DEF = 255;

  localparam int ENTRY_W = 51;  // {flags[2:0], value[15:0], sequence[31:0]}

  localparam logic [15:0] SAMPLE_LIMIT = 16'd4096;
  localparam logic [15:0] MAGIC_HK     = 16'h4B48;
  localparam logic [15:0] MAGIC_L1     = 16'h314C;

  localparam logic [2:0] FLAG_FIRST   = 3'b001;
  localparam logic [2:0] FLAG_FAULT   = 3'b010;
  localparam logic [2:0] FLAG_INVALID = 3'b100;

  localparam logic [2:0] KIND_SAMPLE     = 3'd0;
  localparam logic [2:0] KIND_DRAIN      = 3'd1;
  localparam logic [2:0] KIND_LINK_RESET = 3'd2;
  localparam logic [2:0] KIND_ARM        = 3'd3;
  localparam logic [2:0] KIND_STOP       = 3'd4;

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_SESSION_ID   = 2'd1;
  localparam logic [1:0] REG_SENSOR_INDEX = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic sample;   // apply one sample, close the set on last
    logic arm;
    logic stop;     // flush ring, count its records as dropped
    logic set_rp;   // link reset seen
    logic clr_rp;
    logic insert;   // put the fault record into the empty ring
    logic start;    // load the batch count
    logic rd;       // read ring at the read pointer
    logic load;     // move ring data into the output register
  } scf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic capture_on;
    logic fault_latched;
    logic fault_reported;
    logic reset_pending;
    logic fill_zero;
    logic cnt_last;
    logic out_free;
  } scf_sts_t;

endpackage

[sv/scf_ctrl.sv]
// Sequencer of the sample capture framer: decodes items, runs drain batches.
// Depends on scf_pkg.
module scf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic               in_link_ready,
  input  logic               in_publish_accept,
  input  scf_pkg::scf_sts_t  sts,
  output scf_pkg::scf_cmd_t  cmd
);
  import scf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD   = 3'b010,
    ST_LOAD = 3'b100
  } scf_state_t;

  scf_state_t state_r, state_nxt;
  logic       accept;
  logic       ins;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign ins      = sts.fault_latched & ~sts.fault_reported & sts.fill_zero;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_SAMPLE: cmd.sample = 1'b1;
            KIND_DRAIN: begin
              if (sts.reset_pending || !in_link_ready) begin
                cmd.clr_rp = 1'b1;
                cmd.stop   = 1'b1;
              end else if (sts.capture_on) begin
                cmd.insert = ins;
                if ((!sts.fill_zero || ins) && in_publish_accept) begin
                  cmd.start = 1'b1;
                  state_nxt = ST_RD;
                end
              end
            end
            KIND_LINK_RESET: cmd.set_rp = 1'b1;
            KIND_ARM:        cmd.arm    = 1'b1;
            KIND_STOP:       cmd.stop   = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = sts.cnt_last ? ST_IDLE : ST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/scf_dp.sv]
// Datapath of the sample capture framer: config registers, set checking,
// record ring memory, counters and the output register. Depends on scf_pkg.
module scf_dp #(
  parameter int RING_DEPTH      = scf_pkg::RING_DEPTH_DEF,
  parameter int BATCH_SIZE      = scf_pkg::BATCH_SIZE_DEF,
  parameter int MAX_SET_SAMPLES = scf_pkg::MAX_SET_SAMPLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [15:0]        in_sample,
  input  logic               in_last_sample,
  input  logic [7:0]         in_profile,
  input  logic               in_link_ready,
  input  scf_pkg::scf_cmd_t  cmd,
  output scf_pkg::scf_sts_t  sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [31:0]        out_rec_session,
  output logic [31:0]        out_rec_sequence,
  output logic [15:0]        out_rec_value,
  output logic [7:0]         out_rec_sensor,
  output logic [2:0]         out_rec_flags,
  output logic [15:0]        out_rec_threshold,
  output logic [15:0]        out_rec_checksum,
  output logic               out_last_in_batch,
  output logic [31:0]        out_dropped_total
);
  import scf_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);
  localparam int CW = $clog2(BATCH_SIZE + 1);

  // config
  logic [15:0] thr_r;
  logic [31:0] sess_r;
  logic [7:0]  sidx_r;

  // control state
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   seq_r, seq_nxt, drop_r, drop_nxt;
  logic          cap_r, cap_nxt, first_r, first_nxt, fault_r, fault_nxt;
  logic          rep_r, rep_nxt, rstp_r, rstp_nxt;
  logic [7:0]    prof_r, prof_nxt, pos_r, pos_nxt;
  logic          inv_r, inv_nxt;
  logic [15:0]   pick_r, pick_nxt;
  logic          out_valid_r, out_valid_nxt;

  // ring
  logic [ENTRY_W-1:0] ring_mem [RING_DEPTH];
  logic [ENTRY_W-1:0] mem_q, mem_wd;
  logic [PW-1:0]      mem_wa;
  logic               mem_we;

  // sample path
  logic          s_room, s_inv, idx_ok, c_inv;
  logic [7:0]    s_pos;
  logic [15:0]   s_pick, c_val;
  logic [PW-1:0] wp_inc, rp_inc;

  // output stage
  logic [31:0] o_seq;
  logic [15:0] o_val, o_sum;
  logic [2:0]  o_flg;

  assign s_room = pos_r < 8'(MAX_SET_SAMPLES);
  assign s_inv  = inv_r | (in_sample == 16'd0) | (in_sample > SAMPLE_LIMIT) | ~s_room;
  assign s_pos  = s_room ? pos_r + 8'd1 : pos_r;
  assign s_pick = (s_room && pos_r == sidx_r) ? in_sample : pick_r;
  assign idx_ok = sidx_r < s_pos;
  assign c_inv  = s_inv | ~idx_ok | ((prof_r != 8'd0) && (prof_r != in_profile));
  assign c_val  = idx_ok ? s_pick : 16'd0;

  assign wp_inc = (wp_r == PW'(RING_DEPTH - 1)) ? '0 : wp_r + PW'(1);
  assign rp_inc = (rp_r == PW'(RING_DEPTH - 1)) ? '0 : rp_r + PW'(1);

  always_comb begin
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    seq_nxt       = seq_r;
    drop_nxt      = drop_r;
    cap_nxt       = cap_r;
    first_nxt     = first_r;
    fault_nxt     = fault_r;
    rep_nxt       = rep_r;
    rstp_nxt      = rstp_r;
    prof_nxt      = prof_r;
    pos_nxt       = pos_r;
    inv_nxt       = inv_r;
    pick_nxt      = pick_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    mem_we        = 1'b0;
    mem_wa        = wp_r;
    mem_wd        = {FLAG_INVALID & {3{c_inv}} | FLAG_FIRST & {3{first_r}}, c_val, seq_r};

    if (cmd.sample) begin
      if (!in_last_sample) begin
        pos_nxt  = s_pos;
        inv_nxt  = s_inv;
        pick_nxt = s_pick;
      end else begin
        pos_nxt  = 8'd0;
        inv_nxt  = 1'b0;
        pick_nxt = 16'd0;
        if (cap_r && !fault_r) begin
          if (rstp_r || !in_link_ready || fill_r == FW'(RING_DEPTH)) begin
            drop_nxt  = drop_r + 32'd1;
            fault_nxt = 1'b1;
          end else begin
            mem_we    = 1'b1;
            prof_nxt  = in_profile;
            seq_nxt   = seq_r + 32'd1;
            first_nxt = 1'b0;
            wp_nxt    = wp_inc;
            fill_nxt  = fill_r + FW'(1);
            fault_nxt = c_inv;
          end
        end
      end
    end

    if (cmd.stop || cmd.arm) begin
      cap_nxt  = 1'b0;
      drop_nxt = drop_r + 32'(fill_r);
      wp_nxt   = '0;
      rp_nxt   = '0;
      fill_nxt = '0;
      pos_nxt  = 8'd0;
      inv_nxt  = 1'b0;
      pick_nxt = 16'd0;
    end
    if (cmd.arm) begin
      first_nxt = 1'b1;
      fault_nxt = 1'b0;
      rep_nxt   = 1'b0;
      seq_nxt   = 32'd0;
      prof_nxt  = 8'd0;
      cap_nxt   = in_link_ready;
    end
    if (cmd.set_rp) rstp_nxt = 1'b1;
    if (cmd.clr_rp) rstp_nxt = 1'b0;

    if (cmd.insert) begin
      mem_we    = 1'b1;
      mem_wa    = '0;
      mem_wd    = {FLAG_FAULT | FLAG_FIRST & {3{first_r}}, 16'd0, seq_r};
      seq_nxt   = seq_r + 32'd1;
      first_nxt = 1'b0;
      wp_nxt    = PW'(1);
      rp_nxt    = '0;
      fill_nxt  = FW'(1);
      rep_nxt   = 1'b1;
    end
    if (cmd.start) begin
      if (cmd.insert) begin
        cnt_nxt = CW'(1);
      end else if ({{CW{1'b0}}, fill_r} < (FW + CW)'(BATCH_SIZE)) begin
        cnt_nxt = CW'(fill_r);
      end else begin
        cnt_nxt = CW'(BATCH_SIZE);
      end
    end

    if (cmd.load) begin
      rp_nxt        = rp_inc;
      fill_nxt      = fill_r - FW'(1);
      cnt_nxt       = cnt_r - CW'(1);
      out_valid_nxt = 1'b1;
    end
  end

  // record fields and checksum over the magic words, session, sequence, value, flags, sensor and threshold
  assign o_seq = mem_q[31:0];
  assign o_val = mem_q[47:32];
  assign o_flg = mem_q[50:48];
  assign o_sum = MAGIC_HK + MAGIC_L1 + sess_r[15:0] + sess_r[31:16]
               + o_seq[15:0] + o_seq[31:16] + o_val + {5'd0, o_flg, sidx_r} + thr_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      mem_q <= ring_mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_rec_session   <= sess_r;
      out_rec_sequence  <= o_seq;
      out_rec_value     <= o_val;
      out_rec_sensor    <= sidx_r;
      out_rec_flags     <= o_flg;
      out_rec_threshold <= thr_r;
      out_rec_checksum  <= o_sum;
      out_last_in_batch <= (cnt_r == CW'(1));
      out_dropped_total <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 16'd0;
      sess_r      <= 32'd0;
      sidx_r      <= 8'd255;
      wp_r        <= '0;
      rp_r        <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      seq_r       <= 32'd0;
      drop_r      <= 32'd0;
      cap_r       <= 1'b0;
      first_r     <= 1'b0;
      fault_r     <= 1'b0;
      rep_r       <= 1'b0;
      rstp_r      <= 1'b0;
      prof_r      <= 8'd0;
      pos_r       <= 8'd0;
      inv_r       <= 1'b0;
      pick_r      <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_THRESHOLD:    thr_r  <= cfg_data[15:0];
          REG_SESSION_ID:   sess_r <= cfg_data;
          REG_SENSOR_INDEX: sidx_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      seq_r       <= seq_nxt;
      drop_r      <= drop_nxt;
      cap_r       <= cap_nxt;
      first_r     <= first_nxt;
      fault_r     <= fault_nxt;
      rep_r       <= rep_nxt;
      rstp_r      <= rstp_nxt;
      prof_r      <= prof_nxt;
      pos_r       <= pos_nxt;
      inv_r       <= inv_nxt;
      pick_r      <= pick_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.capture_on     = cap_r;
    sts.fault_latched  = fault_r;
    sts.fault_reported = rep_r;
    sts.reset_pending  = rstp_r;
    sts.fill_zero      = (fill_r == '0);
    sts.cnt_last       = (cnt_r == CW'(1));
    sts.out_free       = ~out_valid_r | out_ready;
  end

endmodule

[sv/sample_capture_framer.sv]
// Channel   | Handshake              | Carries
// in        | in_valid / in_ready    | kind, sample, last_sample, profile, link_ready,
//           |                        | publish_accept
// out       | out_valid / out_ready  | one framed record per transfer
// cfg       | cfg_valid / cfg_ready  | register index and write data
//
// Sample, arm, stop and link reset items are taken back to back.
// A drain is decided in the idle state, then each record passes the ring read register,
// then the output register load; a stalled output holds the load back. The next item
// is taken once the last record of the batch sits in the output register.
// Reset is synchronous; the ring memory is not cleared and needs no clearing pass.
// cfg_ready is always high.
//
// Top level of the sample capture framer; depends on scf_pkg, scf_ctrl, scf_dp
// and sample_capture_framer_assert.svh.
`include "sample_capture_framer_assert.svh"

module sample_capture_framer #(
  parameter int RING_DEPTH      = scf_pkg::RING_DEPTH_DEF,
  parameter int BATCH_SIZE      = scf_pkg::BATCH_SIZE_DEF,
  parameter int MAX_SET_SAMPLES = scf_pkg::MAX_SET_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_sample,
  input  logic        in_last_sample,
  input  logic [7:0]  in_profile,
  input  logic        in_link_ready,
  input  logic        in_publish_accept,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rec_session,
  output logic [31:0] out_rec_sequence,
  output logic [15:0] out_rec_value,
  output logic [7:0]  out_rec_sensor,
  output logic [2:0]  out_rec_flags,
  output logic [15:0] out_rec_threshold,
  output logic [15:0] out_rec_checksum,
  output logic        out_last_in_batch,
  output logic [31:0] out_dropped_total,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import scf_pkg::*;

  scf_cmd_t cmd;
  scf_sts_t sts;

  assign cfg_ready = 1'b1;

  scf_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_link_ready     (in_link_ready),
    .in_publish_accept (in_publish_accept),
    .sts               (sts),
    .cmd               (cmd)
  );

  scf_dp #(
    .RING_DEPTH      (RING_DEPTH),
    .BATCH_SIZE      (BATCH_SIZE),
    .MAX_SET_SAMPLES (MAX_SET_SAMPLES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .in_profile        (in_profile),
    .in_link_ready     (in_link_ready),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_rec_session   (out_rec_session),
    .out_rec_sequence  (out_rec_sequence),
    .out_rec_value     (out_rec_value),
    .out_rec_sensor    (out_rec_sensor),
    .out_rec_flags     (out_rec_flags),
    .out_rec_threshold (out_rec_threshold),
    .out_rec_checksum  (out_rec_checksum),
    .out_last_in_batch (out_last_in_batch),
    .out_dropped_total (out_dropped_total)
  );

  // input stays blocked while a batch is being read out
  `SCF_ASSERT_NOW(a_busy_blocks_in, cmd.rd || cmd.load, !in_ready, "input taken during batch")
  // a load never overwrites a record that has not been transferred
  `SCF_ASSERT_NOW(a_load_free, cmd.load, sts.out_free, "output register overwritten")
  // output valid only appears after a load
  `SCF_ASSERT_NEXT(a_valid_src, !out_valid && !cmd.load, !out_valid, "spurious out_valid")
  // last record of a batch frees the input side
  `SCF_ASSERT_NEXT(a_batch_end, cmd.load && sts.cnt_last, in_ready, "batch did not end")

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for sample_capture_framer: drives items and register writes,
// predicts framed records in step and checks every transfer on the record channel.
// Depends on scf_pkg and the sample_capture_framer RTL.
module tb;
  import scf_pkg::*;

  localparam int DEPTH   = RING_DEPTH_DEF;
  localparam int BATCH   = BATCH_SIZE_DEF;
  localparam int MAX_SET = MAX_SET_SAMPLES_DEF;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
  localparam logic [1:0] REG_UNUSED        = 2'd3;

  typedef struct packed {
    logic [2:0]  flags;
    logic [15:0] value;
    logic [31:0] seq_no;
  } ring_entry_t;

  typedef struct packed {
    logic [31:0] session;
    logic [31:0] seq_no;
    logic [15:0] value;
    logic [7:0]  sensor;
    logic [2:0]  flags;
    logic [15:0] threshold;
    logic [15:0] checksum;
    logic        last_in_batch;
    logic [31:0] dropped;
  } framed_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [15:0] in_sample;
  logic        in_last_sample;
  logic [7:0]  in_profile;
  logic        in_link_ready;
  logic        in_publish_accept;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_rec_session;
  logic [31:0] out_rec_sequence;
  logic [15:0] out_rec_value;
  logic [7:0]  out_rec_sensor;
  logic [2:0]  out_rec_flags;
  logic [15:0] out_rec_threshold;
  logic [15:0] out_rec_checksum;
  logic        out_last_in_batch;
  logic [31:0] out_dropped_total;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // predicted framer state, mirrors the block after every accepted item
  logic [15:0] thr_reg     = 16'd0;
  logic [31:0] session_reg = 32'd0;
  logic [7:0]  sensor_reg  = 8'hFF;
  ring_entry_t ring_mem [DEPTH];
  int unsigned wr_ptr = 0, rd_ptr = 0, fill = 0;
  logic [31:0] next_seq = 32'd0, drops = 32'd0;
  bit          capturing = 0, first_mark = 0, faulted = 0, fault_sent = 0;
  bit          link_reset_seen = 0;
  logic [7:0]  last_profile = 8'd0, sample_pos = 8'd0;
  bit          set_bad = 0;
  logic [15:0] picked = 16'd0;

  framed_rec_t records_due [$];
  int unsigned errors = 0, records_seen = 0, items_fed = 0;
  bit          calm = 0;

  sample_capture_framer dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_error(input string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [31:0] seq);
    if (got !== want)
      flag_error($sformatf("%s on record seq %0d: got 0x%0h, want 0x%0h",
                           name, seq, got, want));
  endtask

  function automatic void discard_set();
    sample_pos = 8'd0;
    set_bad    = 0;
    picked     = 16'd0;
  endfunction

  function automatic void halt_capture();
    capturing = 0;
    drops     = drops + fill;
    wr_ptr    = 0;
    rd_ptr    = 0;
    fill      = 0;
    discard_set();
  endfunction

  function automatic ring_entry_t make_entry(input logic [15:0] v, input logic [2:0] f);
    ring_entry_t e;
    e.seq_no   = next_seq;
    e.value    = v;
    e.flags    = f | (first_mark ? FLAG_FIRST : 3'b000);
    next_seq   = next_seq + 32'd1;
    first_mark = 0;
    return e;
  endfunction

  // Advances the predicted state by one accepted item and queues the records it emits.
  task automatic step_framer(input logic [2:0] k, input logic [15:0] s, input logic l,
                             input logic [7:0] p, input logic lr, input logic pa);
    bit          bad;
    logic [15:0] v;
    int unsigned n;
    ring_entry_t e;
    framed_rec_t r;
    case (k)
      KIND_SAMPLE: begin
        if (s == 16'd0 || s > SAMPLE_LIMIT) set_bad = 1;
        if (sample_pos >= MAX_SET) begin
          set_bad = 1;  // past the set limit: range checked, not counted
        end else begin
          if (sample_pos == sensor_reg) picked = s;
          sample_pos++;
        end
        if (l && capturing && !faulted) begin
          if (link_reset_seen || !lr || fill >= DEPTH) begin
            drops   = drops + 32'd1;
            faulted = 1;
          end else begin
            bad = set_bad;
            if (sensor_reg >= sample_pos) bad = 1;
            if (last_profile != 8'd0 && last_profile != p) bad = 1;
            last_profile = p;
            v = (sensor_reg < sample_pos) ? picked : 16'd0;
            ring_mem[wr_ptr] = make_entry(v, bad ? FLAG_INVALID : 3'b000);
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
            if (bad) faulted = 1;
          end
        end
        if (l) discard_set();
      end
      KIND_DRAIN: begin
        if (link_reset_seen || !lr) begin
          link_reset_seen = 0;
          halt_capture();
        end else if (capturing) begin
          if (faulted && !fault_sent && fill == 0) begin
            ring_mem[0] = make_entry(16'd0, FLAG_FAULT);
            wr_ptr      = 1 % DEPTH;
            rd_ptr      = 0;
            fill        = 1;
            fault_sent  = 1;
          end
          if (fill != 0 && pa) begin
            n = (fill < BATCH) ? fill : BATCH;
            for (int i = 0; i < n; i++) begin
              e = ring_mem[(rd_ptr + i) % DEPTH];
              r.session       = session_reg;
              r.seq_no        = e.seq_no;
              r.value         = e.value;
              r.sensor        = sensor_reg;
              r.flags         = e.flags;
              r.threshold     = thr_reg;
              r.checksum      = MAGIC_HK + MAGIC_L1 + session_reg[15:0] + session_reg[31:16]
                                + e.seq_no[15:0] + e.seq_no[31:16] + e.value
                                + {5'd0, e.flags, sensor_reg} + thr_reg;
              r.last_in_batch = (i + 1 == n);
              r.dropped       = drops;
              records_due.push_back(r);
            end
            rd_ptr = (rd_ptr + n) % DEPTH;
            fill   = fill - n;
          end
        end
      end
      KIND_LINK_RESET: link_reset_seen = 1;
      KIND_ARM: begin
        halt_capture();
        first_mark   = 1;
        faulted      = 0;
        fault_sent   = 0;
        next_seq     = 32'd0;
        last_profile = 8'd0;
        capturing    = lr;
      end
      KIND_STOP: halt_capture();
      default: ;
    endcase
  endtask

  task automatic feed_item(input logic [2:0] k, input logic [15:0] s, input logic l,
                           input logic [7:0] p, input logic lr, input logic pa);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_kind           <= k;
    in_sample         <= s;
    in_last_sample    <= l;
    in_profile        <= p;
    in_link_ready     <= lr;
    in_publish_accept <= pa;
    do @(posedge clk); while (!in_ready);
    step_framer(k, s, l, p, lr, pa);
    if (k <= KIND_STOP) items_fed++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_THRESHOLD:    thr_reg     = data[15:0];
      REG_SESSION_ID:   session_reg = data;
      REG_SENSOR_INDEX: sensor_reg  = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // hold the sender until every due record is out, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_basic_records();
    write_reg(REG_THRESHOLD, 32'h0000_FFFF);
    write_reg(REG_SESSION_ID, 32'hFFFF_FFFF);
    write_reg(REG_SENSOR_INDEX, 32'd0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);   // capture off
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b0, 1'b0);     // link down: stays off
    feed_item(KIND_SAMPLE, 16'd100, 1'b1, 8'd7, 1'b1, 1'b1);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd1, 1'b0, 8'd0, 1'b0, 1'b0);
    feed_item(KIND_SAMPLE, SAMPLE_LIMIT, 1'b1, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, SAMPLE_LIMIT, 1'b1, 8'hFF, 1'b1, 1'b0);
    for (int k = KIND_UNUSED_FIRST; k <= KIND_UNUSED_LAST; k++)
      feed_item(3'(k), 16'hFFFF, 1'b1, 8'hFF, 1'b1, 1'b1);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);   // refused, records kept
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_fault_paths();
    wait_idle();
    write_reg(REG_SENSOR_INDEX, 32'd255);  // index beyond any set
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd9, 1'b1, 8'd3, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd9, 1'b1, 8'd3, 1'b1, 1'b0);  // dropped silently, faulted
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);   // fault record inserted, held
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);   // fault already reported
    wait_idle();
    write_reg(REG_SENSOR_INDEX, 32'd1);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd0, 1'b0, 8'd4, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd5, 1'b1, 8'd4, 1'b1, 1'b0);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, SAMPLE_LIMIT + 16'd1, 1'b0, 8'd4, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd6, 1'b1, 8'd4, 1'b1, 1'b0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd7, 1'b0, 8'd4, 1'b0, 1'b0);
    feed_item(KIND_SAMPLE, 16'd8, 1'b1, 8'd4, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd9, 1'b0, 8'd5, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd10, 1'b1, 8'd5, 1'b1, 1'b0);  // profile changed
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_link_loss();
    wait_idle();
    write_reg(REG_SENSOR_INDEX, 32'd0);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd11, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd12, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_STOP, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);    // both records lost
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd13, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_LINK_RESET, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd14, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);   // clears the link reset, stops
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd15, 1'b1, 8'd1, 1'b0, 1'b0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b0, 1'b1);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    feed_item(KIND_SAMPLE, 16'd16, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);     // re-arm over a stored record
    feed_item(KIND_SAMPLE, 16'd17, 1'b1, 8'd1, 1'b1, 1'b0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_ring_full();
    wait_idle();
    write_reg(REG_SENSOR_INDEX, 32'd0);
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    for (int i = 0; i <= DEPTH; i++)
      feed_item(KIND_SAMPLE, 16'($urandom_range(1, SAMPLE_LIMIT)), 1'b1, 8'd2, 1'b1, 1'b0);
    // the last set finds the ring full; then empty it and pick up the fault record
    for (int i = 0; i <= DEPTH / BATCH + 1; i++)
      feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
  endtask

  // one set a sample past the limit; the picked sample is the last one counted
  task automatic test_long_set();
    wait_idle();
    write_reg(REG_SENSOR_INDEX, 32'(MAX_SET - 1));
    feed_item(KIND_ARM, 16'd0, 1'b0, 8'd0, 1'b1, 1'b0);
    for (int j = 0; j <= MAX_SET; j++)
      feed_item(KIND_SAMPLE, 16'($urandom_range(1, SAMPLE_LIMIT)), j == MAX_SET, 8'd9,
                1'b1, 1'b0);
    feed_item(KIND_DRAIN, 16'd0, 1'b0, 8'd0, 1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned goal, len, pick;
    logic [7:0]  scan_prof, prof;
    logic [15:0] s;
    bit          last;
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          write_reg(REG_THRESHOLD, 32'd0);
          write_reg(REG_SESSION_ID, 32'd0);
          write_reg(REG_SENSOR_INDEX, 32'd0);
        end
        1: begin
          write_reg(REG_THRESHOLD, 32'h0000_FFFF);
          write_reg(REG_SESSION_ID, 32'hFFFF_FFFF);
          write_reg(REG_SENSOR_INDEX, 32'd255);
        end
        default: begin
          write_reg(REG_THRESHOLD, 32'($urandom_range(0, 16'hFFFF)));
          write_reg(REG_SESSION_ID, $urandom);
          write_reg(REG_SENSOR_INDEX, 32'($urandom_range(0, 4)));
          if (ph == 2) write_reg(REG_UNUSED, $urandom);
        end
      endcase
      if (ph == 4) calm = 1;
      scan_prof = 8'($urandom);
      goal = items_fed + 10;
      while (items_fed < goal) begin
        pick = $urandom_range(0, 99);
        if ((!capturing || faulted) && $urandom_range(0, 1) == 1) begin
          feed_item(KIND_ARM, 16'($urandom), 1'($urandom), 8'($urandom),
                    $urandom_range(0, 9) != 0, 1'($urandom));
        end else if (pick < 58) begin
          len = (sensor_reg < 8'd250 && $urandom_range(0, 9) != 0) ?
                sensor_reg + $urandom_range(1, 4) : $urandom_range(1, 6);
          prof = ($urandom_range(0, 19) == 0) ? 8'($urandom) : scan_prof;
          for (int j = 0; j < len; j++) begin
            last = (j == len - 1);
            s = ($urandom_range(0, 29) == 0) ? 16'($urandom) :
                16'($urandom_range(1, SAMPLE_LIMIT));
            feed_item(KIND_SAMPLE, s, last, prof,
                      last ? ($urandom_range(0, 19) != 0) : 1'($urandom), 1'($urandom));
          end
        end else if (pick < 78) begin
          feed_item(KIND_DRAIN, 16'($urandom), 1'($urandom), 8'($urandom),
                    $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
        end else if (pick < 82) begin
          feed_item(KIND_ARM, 16'($urandom), 1'($urandom), 8'($urandom),
                    $urandom_range(0, 9) != 0, 1'($urandom));
        end else if (pick < 85) begin
          feed_item(KIND_STOP, 16'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
        end else if (pick < 88) begin
          feed_item(KIND_LINK_RESET, 16'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
        end else if (pick < 91) begin
          feed_item(3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST)), 16'($urandom),
                    1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        end else if (pick < 94) begin
          wait_idle();
        end else begin
          feed_item(3'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // receiver side: random stall bursts until the quiet tail of the run
  initial begin
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    framed_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      records_seen++;
      if (records_due.size() == 0) begin
        flag_error($sformatf("record transfer with nothing due, seq %0d", out_rec_sequence));
      end else begin
        want = records_due.pop_front();
        check_field("session", out_rec_session, want.session, want.seq_no);
        check_field("sequence", out_rec_sequence, want.seq_no, want.seq_no);
        check_field("value", 32'(out_rec_value), 32'(want.value), want.seq_no);
        check_field("sensor", 32'(out_rec_sensor), 32'(want.sensor), want.seq_no);
        check_field("flags", 32'(out_rec_flags), 32'(want.flags), want.seq_no);
        check_field("threshold", 32'(out_rec_threshold), 32'(want.threshold), want.seq_no);
        check_field("checksum", 32'(out_rec_checksum), 32'(want.checksum), want.seq_no);
        check_field("last_in_batch", 32'(out_last_in_batch), 32'(want.last_in_batch),
                    want.seq_no);
        check_field("dropped_total", out_dropped_total, want.dropped, want.seq_no);
      end
    end
  end

  initial begin
    int unsigned guard;
    framed_rec_t lost;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= KIND_SAMPLE;
    in_sample         <= 16'd0;
    in_last_sample    <= 1'b0;
    in_profile        <= 8'd0;
    in_link_ready     <= 1'b0;
    in_publish_accept <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_index         <= REG_THRESHOLD;
    cfg_data          <= 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_records();
    test_fault_paths();
    test_link_loss();
    test_ring_full();
    test_long_set();
    test_random_traffic();

    in_valid <= 1'b0;
    guard = 0;
    while (records_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    while (records_due.size() != 0) begin
      lost = records_due.pop_front();
      flag_error($sformatf("record seq %0d never arrived", lost.seq_no));
    end

    $display("Covered %0d items over directed, ring-full, long-set and random phases.",
             items_fed);
    $display("Checked %0d record transfers; %0d sets or records counted lost.",
             records_seen, drops);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
